// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker in brg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst_n is high.
`define BRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define BRG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/brg_pkg.sv =====
package brg_pkg;

  localparam int COORD_BITS   = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int SQ_W         = 2 * DIFF_W;
  localparam int DIST_W       = DIFF_W;
  localparam int REM_W        = DIST_W + 2;
  localparam int PRE_SHIFT    = 58 - COORD_BITS;
  // Three guard bits cover the CORDIC gain and the diagonal of the input square.
  localparam int CORDIC_W     = DIFF_W + PRE_SHIFT + 3;
  localparam int ACC_W        = 32;
  localparam int CORDIC_STEPS = 32;
  // Input register, square stage and pre-rotation stage, then the CORDIC steps
  // plus the rounding stage.
  localparam int PIPE_LAT     = 3 + CORDIC_STEPS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [DIST_W-1:0]            dist_t;
  typedef logic [ANGLE_BITS-1:0]        angle_t;
  typedef logic [ACC_W-1:0]             acc_t;
  typedef acc_t                         atan_tab_t [CORDIC_STEPS];

  localparam acc_t   HALF_TURN    = acc_t'(1) << (ACC_W - 1);
  localparam acc_t   ROUND_BIAS   = acc_t'(1) << (ACC_W - 1 - ANGLE_BITS);
  localparam angle_t QUARTER_TURN = angle_t'(1) << (ANGLE_BITS - 2);

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
  localparam atan_tab_t ATAN_TURNS = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

// ===== hw/rtl/brg_cordic.sv =====
module brg_cordic (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  brg_pkg::diff_t  dx,
  input  brg_pkg::diff_t  dy,
  output logic            out_vld,
  output brg_pkg::angle_t bearing
);
  import brg_pkg::*;

  logic signed [CORDIC_W-1:0] u_r   [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] v_r   [CORDIC_STEPS+1];
  acc_t                       acc_r [CORDIC_STEPS+1];
  logic                       zero_r [CORDIC_STEPS+1];
  logic                       vld_r [CORDIC_STEPS+1];

  logic signed [CORDIC_W-1:0] u_ext, v_ext;
  logic signed [CORDIC_W-1:0] u0_nxt, v0_nxt;
  acc_t                       acc0_nxt;
  logic                       zero0_nxt;
  acc_t                       acc_rnd;
  angle_t                     bearing_nxt;
  angle_t                     bearing_r;
  logic                       out_vld_r;

  // Pre-rotation: fold the lower half plane into the upper one by a half turn.
  always_comb begin
    u_ext = {{(CORDIC_W-DIFF_W){dy[DIFF_W-1]}}, dy} <<< PRE_SHIFT;
    v_ext = {{(CORDIC_W-DIFF_W){dx[DIFF_W-1]}}, dx} <<< PRE_SHIFT;
    if (dy[DIFF_W-1]) begin
      u0_nxt   = -u_ext;
      v0_nxt   = -v_ext;
      acc0_nxt = HALF_TURN;
    end else begin
      u0_nxt   = u_ext;
      v0_nxt   = v_ext;
      acc0_nxt = '0;
    end
    zero0_nxt = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk) begin
    u_r[0]    <= u0_nxt;
    v_r[0]    <= v0_nxt;
    acc_r[0]  <= acc0_nxt;
    zero_r[0] <= zero0_nxt;
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] us, vs;
    logic signed [CORDIC_W-1:0] u_nxt, v_nxt;
    acc_t                       acc_nxt;

    // Drive v toward zero; the rotation direction follows the sign of v.
    always_comb begin
      us = u_r[i] >>> i;
      vs = v_r[i] >>> i;
      if (!v_r[i][CORDIC_W-1]) begin
        u_nxt   = u_r[i] + vs;
        v_nxt   = v_r[i] - us;
        acc_nxt = acc_r[i] + ATAN_TURNS[i];
      end else begin
        u_nxt   = u_r[i] - vs;
        v_nxt   = v_r[i] + us;
        acc_nxt = acc_r[i] - ATAN_TURNS[i];
      end
    end

    always_ff @(posedge clk) begin
      u_r[i+1]    <= u_nxt;
      v_r[i+1]    <= v_nxt;
      acc_r[i+1]  <= acc_nxt;
      zero_r[i+1] <= zero_r[i];
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  always_comb begin
    acc_rnd = acc_r[CORDIC_STEPS] + ROUND_BIAS;
    if (zero_r[CORDIC_STEPS]) begin
      bearing_nxt = QUARTER_TURN;
    end else begin
      bearing_nxt = acc_rnd[ACC_W-1 -: ANGLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    bearing_r <= bearing_nxt;
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[CORDIC_STEPS];
    end
  end

  assign bearing = bearing_r;
  assign out_vld = out_vld_r;

endmodule

// ===== hw/rtl/brg_isqrt.sv =====
module brg_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  brg_pkg::sq_t   sqx,
  input  brg_pkg::sq_t   sqy,
  output logic           out_vld,
  output brg_pkg::dist_t root
);
  import brg_pkg::*;

  localparam int STAGES = SQ_W / 2;

  logic [REM_W-1:0] rem_r  [STAGES+1];
  dist_t            root_r [STAGES+1];
  sq_t              rad_r  [STAGES+1];
  logic             vld_r  [STAGES+1];

  always_ff @(posedge clk) begin
    rad_r[0]  <= sqx + sqy;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  // One root bit per stage, taking two radicand bits from the top each time.
  for (genvar k = 0; k < STAGES; k++) begin : g_digit
    logic [REM_W+1:0] cur, trial, diff;
    logic             ge;
    logic [REM_W-1:0] rem_nxt;
    dist_t            root_nxt;
    sq_t              rad_nxt;

    always_comb begin
      cur      = {rem_r[k], rad_r[k][SQ_W-1 -: 2]};
      trial    = {{(REM_W-DIST_W){1'b0}}, root_r[k], 2'b01};
      diff     = cur - trial;
      ge       = (cur >= trial);
      rem_nxt  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      root_nxt = {root_r[k][DIST_W-2:0], ge};
      rad_nxt  = {rad_r[k][SQ_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= rem_nxt;
      root_r[k+1] <= root_nxt;
      rad_r[k+1]  <= rad_nxt;
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  assign root    = root_r[STAGES];
  assign out_vld = vld_r[STAGES];

endmodule

// ===== hw/rtl/bearing_and_range_core.sv =====
// Channel   Ports                                      Transfer
// request   start, busy, in_own_x/y, in_target_x/y     start high while busy low
// result    out_valid, out_bearing, out_distance       out_valid high for one cycle
//
// A request is taken in every cycle; busy is tied low, reset included.
// Each result follows its request through one input register, one squaring stage,
// one pre-rotation stage, 32 CORDIC steps and a rounding stage, with the square
// root (a sum stage and 33 digit stages) running alongside. Synchronous active-low
// reset clears all valid bits at once. The receiver cannot stall, so no back
// pressure reaches the input.
module bearing_and_range_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  brg_pkg::coord_t  in_own_x,
  input  brg_pkg::coord_t  in_own_y,
  input  brg_pkg::coord_t  in_target_x,
  input  brg_pkg::coord_t  in_target_y,
  output logic             out_valid,
  output brg_pkg::angle_t  out_bearing,
  output brg_pkg::dist_t   out_distance
);
  import brg_pkg::*;

  diff_t            dx_nxt, dy_nxt;
  diff_t            dx_r, dy_r;
  logic             vld_a_r;
  logic [DIFF_W-1:0] mx, my;
  sq_t              sqx_nxt, sqy_nxt;
  sq_t              sqx_r, sqy_r;
  diff_t            dx_b_r, dy_b_r;
  logic             vld_b_r;
  logic             cd_vld, sq_vld;

  always_comb begin
    dx_nxt = {in_target_x[COORD_BITS-1], in_target_x} - {in_own_x[COORD_BITS-1], in_own_x};
    dy_nxt = {in_target_y[COORD_BITS-1], in_target_y} - {in_own_y[COORD_BITS-1], in_own_y};
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= start && !busy;
    end
  end

  // The most negative difference magnitude still fits as an unsigned value.
  always_comb begin
    mx      = dx_r[DIFF_W-1] ? -dx_r : dx_r;
    my      = dy_r[DIFF_W-1] ? -dy_r : dy_r;
    sqx_nxt = {{DIFF_W{1'b0}}, mx} * {{DIFF_W{1'b0}}, mx};
    sqy_nxt = {{DIFF_W{1'b0}}, my} * {{DIFF_W{1'b0}}, my};
  end

  always_ff @(posedge clk) begin
    sqx_r  <= sqx_nxt;
    sqy_r  <= sqy_nxt;
    dx_b_r <= dx_r;
    dy_b_r <= dy_r;
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
  end

  brg_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_b_r),
    .dx      (dx_b_r),
    .dy      (dy_b_r),
    .out_vld (cd_vld),
    .bearing (out_bearing)
  );

  brg_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_b_r),
    .sqx     (sqx_r),
    .sqy     (sqy_r),
    .out_vld (sq_vld),
    .root    (out_distance)
  );

  assign busy      = 1'b0;
  assign out_valid = cd_vld && sq_vld;

endmodule

// ===== hw/rtl/brg_checker.sv =====
`include "assert_macros.svh"

module brg_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input brg_pkg::coord_t in_own_x,
  input brg_pkg::coord_t in_own_y,
  input brg_pkg::coord_t in_target_x,
  input brg_pkg::coord_t in_target_y,
  input logic            out_valid,
  input brg_pkg::angle_t out_bearing,
  input brg_pkg::dist_t  out_distance
);
  import brg_pkg::*;

  diff_t             x_diff;
  logic [DIFF_W-1:0] x_span;

  always_comb begin
    x_diff = {in_target_x[COORD_BITS-1], in_target_x} - {in_own_x[COORD_BITS-1], in_own_x};
    x_span = x_diff[DIFF_W-1] ? -x_diff : x_diff;
  end

  `BRG_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result strobe after reset")
  `BRG_ASSERT(a_result_has_request, out_valid |-> $past(start && !busy, PIPE_LAT), "result without request")
  `BRG_ASSERT(a_coincident, out_valid && $past(in_own_x == in_target_x && in_own_y == in_target_y, PIPE_LAT) |-> out_bearing == QUARTER_TURN && out_distance == '0, "coincident points mishandled")
  `BRG_ASSERT(a_east_west_span, out_valid && $past(in_own_y == in_target_y, PIPE_LAT) |-> out_distance == $past(x_span, PIPE_LAT), "distance along an east-west line is wrong")

endmodule

bind bearing_and_range_core brg_checker u_brg_checker (.*);
